>>> rtl/ddo_pkg.sv
package ddo_pkg;

  localparam int IN_W      = 32;
  localparam int CFG_W     = 24;
  localparam int POSE_W    = 48;
  localparam int ANG_W     = 32;
  localparam int DELTA_W   = 34;  // holds sum or difference of two sign-extended deltas
  localparam int CV_W      = 34;  // CORDIC x/y/z datapath
  localparam int IDX_W     = 5;   // iteration index, wraps at 32
  localparam int PH_W      = 3;
  localparam int PMAG_W    = 57;  // |p| < 2^57
  localparam int AH_W      = 29;  // |p| >> 28
  localparam int AL_W      = 28;
  localparam int UB_W      = 32;
  localparam int MUL_W     = AH_W + UB_W;
  localparam int TSUM_W    = 62;

  localparam logic [CV_W-1:0] CORDIC_GAIN = CV_W'(34'h026DD3B6A);

  localparam logic CFG_MM    = 1'b0;
  localparam logic CFG_ANGLE = 1'b1;

  // product sequencer phases
  localparam logic [PH_W-1:0] PH_XLO = 3'd0;
  localparam logic [PH_W-1:0] PH_XHI = 3'd1;
  localparam logic [PH_W-1:0] PH_XACC = 3'd2;
  localparam logic [PH_W-1:0] PH_YLO = 3'd3;
  localparam logic [PH_W-1:0] PH_YHI = 3'd4;
  localparam logic [PH_W-1:0] PH_YACC = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DELTA, ST_TURN, ST_PMUL, ST_ROT, ST_FIX, ST_PROD, ST_OUT
  } state_t;

  typedef struct packed {
    logic             load_in;
    logic             delta;
    logic             turn;
    logic             pmul;
    logic             rot;
    logic             fix;
    logic             prod;
    logic             out_load;
    logic [IDX_W-1:0] idx;
    logic [PH_W-1:0]  phase;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // arctangent of 2^-i in binary-angle units
  function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ddo_ctrl.sv
module ddo_ctrl
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [PH_W-1:0]  phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    phase_next = phase;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.phase  = phase;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
        if (s_tvalid) state_next = ST_DELTA;
      end
      ST_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = ST_TURN;
      end
      ST_TURN: begin
        cmd.turn   = 1'b1;
        state_next = ST_PMUL;
      end
      ST_PMUL: begin
        cmd.pmul   = 1'b1;
        idx_next   = '0;
        state_next = ST_ROT;
      end
      ST_ROT: begin
        cmd.rot  = 1'b1;
        idx_next = idx + IDX_W'(1);
        if (idx == IDX_W'(CORDIC_STEPS - 1)) state_next = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix    = 1'b1;
        phase_next = PH_XLO;
        state_next = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod   = 1'b1;
        phase_next = phase + PH_W'(1);
        if (phase == PH_YACC) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/ddo_dp.sv
module ddo_dp
  import ddo_pkg::*;
#(
  parameter int POSITION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [2*IN_W-1:0]     s_tdata,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [2*POSE_W+ANG_W-1:0] m_tdata,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  localparam int PB = POSITION_BITS;

  logic [CFG_W-1:0]  mm_per_step, angle_per_step;
  logic [PB-1:0]     in_left, in_right, last_left, last_right;
  logic signed [DELTA_W-1:0] dl, dr;
  logic [ANG_W-1:0]  heading_accum;
  logic signed [POSE_W-1:0] x_accum, y_accum;
  logic              p_neg;
  logic [PMAG_W-1:0] p_mag;
  logic signed [CV_W-1:0] cx, cy, cz;
  logic              flip;
  logic [UB_W-1:0]   uc, us;
  logic              neg_x, neg_y;
  logic [TSUM_W-1:0] tsum;
  logic [2*POSE_W+ANG_W-1:0] out_data;
  logic              out_valid;

  // comb
  logic [PB-1:0]     diff_l, diff_r;
  logic signed [DELTA_W-1:0] step_sum, step_diff;
  logic [ANG_W-1:0]  turn;
  logic signed [DELTA_W+CFG_W:0] p_full;
  logic signed [CV_W-1:0] z0, xs, ys;
  logic signed [CV_W-1:0] c_fin, s_fin;
  logic [AH_W-1:0]   mul_a;
  logic [UB_W-1:0]   mul_b;
  logic [MUL_W-1:0]  prod;
  logic signed [TSUM_W-1:0] r_signed;
  logic signed [POSE_W-1:0] acc_sel, acc_new;
  logic signed [TSUM_W:0] acc_sum;

  assign diff_l    = in_left - last_left;
  assign diff_r    = in_right - last_right;
  assign step_sum  = dl + dr;
  assign step_diff = dl - dr;
  assign turn      = ANG_W'(ANG_W'(-step_sum) * ANG_W'(angle_per_step));
  assign p_full    = step_diff * $signed({1'b0, mm_per_step});

  always_comb begin
    z0 = CV_W'($signed(heading_accum));
    if (z0 > CV_W'(34'sh040000000))       z0 = z0 - CV_W'(34'sh080000000);
    else if (z0 < -CV_W'(34'sh040000000)) z0 = z0 + CV_W'(34'sh080000000);
  end

  assign xs = cx >>> cmd.idx;
  assign ys = cy >>> cmd.idx;
  assign c_fin = flip ? -cx : cx;
  assign s_fin = flip ? -cy : cy;

  always_comb begin
    if (cmd.phase == PH_XLO || cmd.phase == PH_YLO)
      mul_a = AH_W'(p_mag[AL_W-1:0]);
    else
      mul_a = p_mag[PMAG_W-1:AL_W];
    mul_b = (cmd.phase < PH_YLO) ? uc : us;
  end
  assign prod = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_comb begin
    logic signed [TSUM_W-1:0] r;
    r        = $signed({3'b000, tsum[TSUM_W-1:3]});
    acc_sel  = (cmd.phase == PH_XACC) ? x_accum : y_accum;
    r_signed = ((cmd.phase == PH_XACC) ? neg_x : neg_y) ? -r : r;
    acc_sum  = (TSUM_W+1)'(acc_sel) + (TSUM_W+1)'(r_signed);
    if (acc_sum > $signed((TSUM_W+1)'({1'b0, {(POSE_W-1){1'b1}}})))
      acc_new = {1'b0, {(POSE_W-1){1'b1}}};
    else if (acc_sum < -$signed((TSUM_W+1)'({1'b1, {(POSE_W-1){1'b0}}})))
      acc_new = {1'b1, {(POSE_W-1){1'b0}}};
    else
      acc_new = acc_sum[POSE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mm_per_step    <= CFG_W'(65536);
      angle_per_step <= CFG_W'(65536);
      last_left      <= '0;
      last_right     <= '0;
      heading_accum  <= '0;
      x_accum        <= '0;
      y_accum        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MM:    mm_per_step    <= cfg_data;
          CFG_ANGLE: angle_per_step <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.delta) begin
        last_left  <= in_left;
        last_right <= in_right;
      end
      if (cmd.turn) heading_accum <= heading_accum + turn;
      if (cmd.prod && cmd.phase == PH_XACC) x_accum <= acc_new;
      if (cmd.prod && cmd.phase == PH_YACC) y_accum <= acc_new;
      if (cmd.out_load)   out_valid <= 1'b1;
      else if (m_tready)  out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_left  <= s_tdata[PB-1:0];
      in_right <= s_tdata[IN_W+PB-1:IN_W];
    end
    if (cmd.delta) begin
      dl <= DELTA_W'($signed(diff_l));
      dr <= DELTA_W'($signed(diff_r));
    end
    if (cmd.pmul) begin
      p_neg <= p_full[DELTA_W+CFG_W];
      p_mag <= PMAG_W'(p_full[DELTA_W+CFG_W] ? -p_full : p_full);
      cx    <= CORDIC_GAIN;
      cy    <= '0;
      cz    <= z0;
      flip  <= (z0 != CV_W'($signed(heading_accum)));
    end
    if (cmd.rot) begin
      if (!cz[CV_W-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - CV_W'(atan_turn(cmd.idx));
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + CV_W'(atan_turn(cmd.idx));
      end
    end
    if (cmd.fix) begin
      uc    <= UB_W'(c_fin[CV_W-1] ? -c_fin : c_fin);
      us    <= UB_W'(s_fin[CV_W-1] ? -s_fin : s_fin);
      neg_x <= p_neg != c_fin[CV_W-1];
      neg_y <= p_neg != s_fin[CV_W-1];
    end
    if (cmd.prod) begin
      if (cmd.phase == PH_XLO || cmd.phase == PH_YLO)
        tsum <= TSUM_W'(prod[MUL_W-1:AL_W]);
      else if (cmd.phase == PH_XHI || cmd.phase == PH_YHI)
        tsum <= tsum + TSUM_W'(prod);
    end
    if (cmd.out_load) out_data <= {heading_accum, y_accum, x_accum};
  end

  assign status.out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

>>> rtl/differential_drive_odometry.sv
// Channel  Signals                      Payload
// s        s_tvalid s_tready s_tdata    left_position, right_position
// m        m_tvalid m_tready m_tdata    pose_x, pose_y, heading
// cfg      cfg_we cfg_index cfg_data    0: mm_per_step_q16, 1: angle_per_step
//
// One item at a time: each accepted item runs through the CORDIC rotation loop
// and the four-pass shared 29x32 multiplier before its result is loaded.
// Result waits in an output register; the next item is taken while it waits.
// Synchronous active-high reset clears pose, heading, last positions; config resets to 65536.
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS  = 20,
  parameter int POSITION_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // left_position[31:0], right_position[63:32]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [127:0]         m_tdata    // pose_x[47:0], pose_y[95:48], heading[127:96]
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ddo_dp #(.POSITION_BITS(POSITION_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

>>> tb/sv/odometry_checker.sv
module odometry_checker
  import ddo_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [63:0]       s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [127:0]      m_tdata,
  output int                fail_count,
  output int                pending
);

  // lowest field last, to match the m_tdata packing
  typedef struct packed {
    logic [ANG_W-1:0]  hdg;
    logic [POSE_W-1:0] y;
    logic [POSE_W-1:0] x;
  } pose_t;

  localparam longint POSE_HI = 64'sh7FFFFFFFFFFF;
  localparam longint POSE_LO = -POSE_HI - 1;

  logic [23:0] mm_step, ang_step;
  logic [31:0] prev_l, prev_r, hdg_acc;
  longint x_acc, y_acc;
  pose_t pose_q[$];

  function automatic logic [31:0] atan_of(int k);
    logic [31:0] t [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};
    return t[k];
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'($signed(ang));
    flip = 0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000; flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000; flip = 1;
    end
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(atan_of(i));
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += longint'(atan_of(i));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // product over 2^31, truncated toward zero
  function automatic longint scale31(longint a, longint b);
    logic [127:0] ua, ub, pr;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    pr = (ua * ub) >> 31;
    return neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
  endfunction

  function automatic longint clamp_add(longint acc, longint d);
    longint v;
    v = acc + d;
    if (v > POSE_HI) return POSE_HI;
    if (v < POSE_LO) return POSE_LO;
    return v;
  endfunction

  task automatic advance_pose(input logic [31:0] l, input logic [31:0] r);
    longint dl, dr, p, c, s;
    logic [31:0] turn;
    pose_t e;
    dl = longint'($signed(l - prev_l));
    dr = longint'($signed(r - prev_r));
    turn = 32'(-(dl + dr) * longint'(ang_step));
    hdg_acc = hdg_acc + turn;
    rotate(hdg_acc, c, s);
    p = (dl - dr) * longint'(mm_step);
    x_acc = clamp_add(x_acc, scale31(p, c));
    y_acc = clamp_add(y_acc, scale31(p, s));
    prev_l = l;
    prev_r = r;
    e.x = x_acc[47:0];
    e.y = y_acc[47:0];
    e.hdg = hdg_acc;
    pose_q.push_back(e);
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  assign pending = pose_q.size();

  always @(posedge clk) begin
    pose_t e, g;
    if (rst) begin
      mm_step <= 24'd65536; ang_step <= 24'd65536;
      prev_l = 0; prev_r = 0; hdg_acc = 0; x_acc = 0; y_acc = 0;
      pose_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MM) mm_step <= cfg_data;
        else ang_step <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        g = m_tdata[127:0];
        if (pose_q.size() == 0) report("unexpected transaction", '0, '0);
        else begin
          e = pose_q.pop_front();
          if (g.x !== e.x) report("pose_x", 64'(g.x), 64'(e.x));
          if (g.y !== e.y) report("pose_y", 64'(g.y), 64'(e.y));
          if (g.hdg !== e.hdg) report("heading", 64'(g.hdg), 64'(e.hdg));
        end
      end
      if (s_tvalid && s_tready) advance_pose(s_tdata[31:0], s_tdata[63:32]);
    end
  end

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import ddo_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_we = 0, cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;
  logic s_tvalid = 0, m_tready = 0;
  logic [63:0] s_tdata = 0;
  logic s_tready, m_tvalid;
  logic [127:0] m_tdata;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  longint cycles = 0;
  logic [31:0] lpos = 0, rpos = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  differential_drive_odometry i_dut (.*);
  odometry_checker i_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

  task automatic send_item(input logic [31:0] l, input logic [31:0] r);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    s_tvalid <= 1;
    s_tdata <= {r, l};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid <= 0;
    // block is busy after an accept until it loads its result
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // mostly small wheel moves, sometimes big jumps or counter wrap
  task automatic random_move();
    case ($urandom_range(9))
      0: begin lpos = $urandom; rpos = $urandom; end
      1: begin lpos = lpos + 32'h7FFFFFF0; rpos = rpos - 32'h7FFFFFF0; end
      default: begin
        lpos = lpos + 32'($signed($urandom_range(2000)) - 1000);
        rpos = rpos + 32'($signed($urandom_range(2000)) - 1000);
      end
    endcase
    send_item(lpos, rpos);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 0;
    send_item(32'h0, 32'h0);
    send_item(32'h7FFFFFFF, 32'h80000000);
    send_item(32'h80000000, 32'h7FFFFFFF);
    send_item(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(32'h00000010, 32'hFFFFFFF0);
    send_item(32'hFFFFFFF0, 32'h00000010);
    send_item(32'h00001000, 32'h00001000);
    write_reg(CFG_MM, 24'hFFFFFF);
    write_reg(CFG_ANGLE, 24'hFFFFFF);
    // drive far enough to hit the pose saturation limits
    for (int i = 0; i < 12; i++) send_item(i[0] ? 32'h7FFFFFFF : 32'h0,
                                           i[0] ? 32'h80000001 : 32'h0);
    write_reg(CFG_MM, 24'h0);
    write_reg(CFG_ANGLE, 24'h0);
    send_item(32'h12345678, 32'h9ABCDEF0);
    send_item(32'h0, 32'h0);
    lpos = 0; rpos = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 38 : ph == 1 ? 55 : 0;
      recv_idle = ph == 0 ? 55 : ph == 1 ? 38 : 0;
      write_reg(CFG_MM, ph == 2 ? 24'd65536 : 24'($urandom_range(24'hFFFFFF)));
      write_reg(CFG_ANGLE, ph == 1 ? 24'd1 : 24'($urandom_range(24'hFFFFFF)));
      for (int i = 0; i < 630; i++) random_move();
    end
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
